[design/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg: shared types, constants and calendar tables
// Port widths, reciprocal constants for the decimal split, the record types
// passed between pipeline stages and the month tables of a common year.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // Stream widths, each field packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;
    localparam int PACKED_W  = 27;

    // Highest packed value that still reads as DDMMYYYY
    localparam logic [PACKED_W-1:0] PACKED_MAX = 27'd99999999;

    // Reciprocals: floor(p / d) == (p * ceil(2^k / d)) >> k for p <= PACKED_MAX
    localparam int                DIV100_SHIFT = 34;
    localparam logic [27:0]       DIV100_MUL   = 28'd171798692;
    localparam int                DIV1E4_SHIFT = 40;
    localparam logic [27:0]       DIV1E4_MUL   = 28'd109951163;
    localparam int                DIV1E6_SHIFT = 47;
    localparam logic [27:0]       DIV1E6_MUL   = 28'd140737489;
    localparam int                PROD_W       = PACKED_W + 28;

    // Calendar constants
    localparam logic [6:0]  MONTH_FEB      = 7'd2;
    localparam logic [6:0]  MONTH_DEC      = 7'd12;
    localparam logic [21:0] DAYS_PER_CENT  = 22'd36524;
    localparam logic [21:0] DAYS_PER_YEAR  = 22'd365;
    localparam logic [6:0]  LAST_YEAR_LO   = 7'd99;

    // Decimal digit pairs of one date
    typedef struct packed {
        logic       above;    // packed value has no DDMMYYYY reading
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year_hi;  // century digits
        logic [6:0] year_lo;  // year within the century
    } t_digits;

    // One result item
    typedef struct packed {
        logic        date_valid;
        logic [6:0]  day_of_month;
        logic [6:0]  month_number;
        logic [13:0] year_number;
        logic [21:0] day_number;
    } t_result;

    // Days in the months before month m of a common year
    function automatic logic [8:0] days_before_month(input logic [6:0] m);
        logic [8:0] d;
        case (m)
            7'd1:    d = 9'd0;
            7'd2:    d = 9'd31;
            7'd3:    d = 9'd59;
            7'd4:    d = 9'd90;
            7'd5:    d = 9'd120;
            7'd6:    d = 9'd151;
            7'd7:    d = 9'd181;
            7'd8:    d = 9'd212;
            7'd9:    d = 9'd243;
            7'd10:   d = 9'd273;
            7'd11:   d = 9'd304;
            7'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of month m, with February stretched in a leap year
    function automatic logic [4:0] month_length(input logic [6:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                     n = 5'd30;
            7'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

[design/pdc_day_count.sv]
// ----------------------------------------------------------------------------
// pdc_day_count: date check and day count from decimal digit pairs
// Decides validity under the Gregorian leap rule and counts days from
// 01.01.0001 (day 1). Purely combinational; the caller registers the result.
// ----------------------------------------------------------------------------
module pdc_day_count (
    input  pdc_pkg::t_digits i_digits,
    output pdc_pkg::t_result o_result
);
    import pdc_pkg::*;

    logic        w_leap;
    logic        w_year_zero;
    logic        w_ok;
    logic [6:0]  w_cent;      // full centuries before the year
    logic [6:0]  w_rest;      // years past those centuries before the year
    logic [4:0]  w_limit;
    logic [13:0] w_year;
    logic [21:0] w_total;

    // Leap: divisible by 4 but not 100, or by 400
    assign w_leap = (i_digits.year_lo != 7'd0) ? (i_digits.year_lo[1:0] == 2'd0)
                                               : (i_digits.year_hi[1:0] == 2'd0);
    assign w_year_zero = (i_digits.year_hi == 7'd0) && (i_digits.year_lo == 7'd0);

    // Range and month-length check
    assign w_limit = month_length(i_digits.month, w_leap);
    assign w_ok    = !i_digits.above && !w_year_zero
                   && (i_digits.month != 7'd0) && (i_digits.month <= MONTH_DEC)
                   && (i_digits.day != 7'd0)
                   && (i_digits.day <= {2'b00, w_limit});

    // Split year-1 into centuries and remainder
    assign w_cent = (i_digits.year_lo == 7'd0) ? (i_digits.year_hi - 7'd1) : i_digits.year_hi;
    assign w_rest = (i_digits.year_lo == 7'd0) ? LAST_YEAR_LO : (i_digits.year_lo - 7'd1);

    // 365*y1 + y1/4 - y1/100 + y1/400 folded onto centuries and remainder
    assign w_total = 22'(w_cent) * DAYS_PER_CENT + 22'(w_cent[6:2])
                   + 22'(w_rest) * DAYS_PER_YEAR + 22'(w_rest[6:2])
                   + 22'(days_before_month(i_digits.month))
                   + 22'(w_leap && (i_digits.month > MONTH_FEB))
                   + 22'(i_digits.day);

    assign w_year = 14'(i_digits.year_hi) * 14'd100 + 14'(i_digits.year_lo);

    // Zero everything for an out-of-range packed value
    always_comb begin
        if (i_digits.above) begin
            o_result = '0;
        end else begin
            o_result.date_valid   = w_ok;
            o_result.day_of_month = i_digits.day;
            o_result.month_number = i_digits.month;
            o_result.year_number  = w_year;
            o_result.day_number   = w_ok ? w_total : 22'd0;
        end
    end

endmodule

[design/packed_date_check_and_day_number_top.sv]
// ----------------------------------------------------------------------------
// packed_date_check_and_day_number_top: packed date checker and day counter
// Splits a DDMMYYYY decimal date, checks it and returns its day number.
// ----------------------------------------------------------------------------
// Takes one date per clock while o_s_tready is high, as a decimal integer
// DDMMYYYY in i_s_tdata, and returns one result per date, in order, through
// an input register, a constant-reciprocal multiply stage that pulls out the
// digit pairs, a stage that finishes the decimal split, and a result register
// fed by the validity check and day count. Each stage holds its transaction
// only while the one after it is full and stalled, so gaps on either side are
// absorbed and a full pipeline sustains one transaction per cycle while the
// output is not stalled. date_valid travels in o_m_tuser; an invalid date
// has day number 0, and a packed value above 99999999 gives all-zero fields.
module packed_date_check_and_day_number_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pdc_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [26:0] packed_date
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pdc_pkg::M_TDATA_W-1:0]  o_m_tdata,   // [6:0] day_of_month,
                                                        // [13:7] month_number,
                                                        // [27:14] year_number,
                                                        // [49:28] day_number
    output logic                           o_m_tuser    // [0] date_valid
);
    import pdc_pkg::*;

    // Stage valid flags and readiness
    logic r_v0, r_v1, r_v2, r_v3;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3;

    // Stage payloads
    logic [PACKED_W-1:0] r_packed;
    logic                r_s1_above;
    logic [6:0]          r_s1_p_lo;
    logic [6:0]          r_s1_q100_lo;
    logic [6:0]          r_s1_q1e4_lo;
    logic [6:0]          r_s1_day;
    t_digits             r_digits;
    t_result             r_result;

    // Next values
    logic [PROD_W-1:0]   n_prod100;
    logic [PROD_W-1:0]   n_prod1e4;
    logic [PROD_W-1:0]   n_prod1e6;
    t_digits             n_digits;
    t_result             n_result;

    // A stage may load when empty or when its contents move on
    assign w_rdy3     = !r_v3 || i_m_tready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign w_rdy0     = !r_v0 || w_rdy1;
    assign o_s_tready = w_rdy0;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_s_tvalid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Reciprocal multiplies for /100, /10000 and /1000000
    assign n_prod100 = PROD_W'(r_packed) * PROD_W'(DIV100_MUL);
    assign n_prod1e4 = PROD_W'(r_packed) * PROD_W'(DIV1E4_MUL);
    assign n_prod1e6 = PROD_W'(r_packed) * PROD_W'(DIV1E6_MUL);

    // Finish the split with mod-128 arithmetic; every digit pair of an in-range value is below 100
    always_comb begin
        n_digits.above   = r_s1_above;
        n_digits.day     = r_s1_day;
        n_digits.month   = r_s1_q1e4_lo - 7'(r_s1_day * 7'd100);
        n_digits.year_hi = r_s1_q100_lo - 7'(r_s1_q1e4_lo * 7'd100);
        n_digits.year_lo = r_s1_p_lo - 7'(r_s1_q100_lo * 7'd100);
    end

    pdc_day_count u_day_count (
        .i_digits (r_digits),
        .o_result (n_result)
    );

    // Payload registers, loaded with their stage
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_packed <= i_s_tdata[PACKED_W-1:0];
        end
        if (w_rdy1) begin
            r_s1_above   <= (r_packed > PACKED_MAX);
            r_s1_p_lo    <= r_packed[6:0];
            r_s1_q100_lo <= n_prod100[DIV100_SHIFT+6:DIV100_SHIFT];
            r_s1_q1e4_lo <= n_prod1e4[DIV1E4_SHIFT+6:DIV1E4_SHIFT];
            r_s1_day     <= n_prod1e6[DIV1E6_SHIFT+6:DIV1E6_SHIFT];
        end
        if (w_rdy2) begin
            r_digits <= n_digits;
        end
        if (w_rdy3) begin
            r_result <= n_result;
        end
    end

    // Drive the result transaction
    assign o_m_tvalid = r_v3;
    assign o_m_tuser  = r_result.date_valid;
    assign o_m_tdata  = {6'd0, r_result.day_number, r_result.year_number,
                         r_result.month_number, r_result.day_of_month};

endmodule
